// ----- hdl/brsq_pkg.sv -----
package brsq_pkg;

   // ring storage geometry
   localparam int DEPTH    = 4096;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int BYTE_W   = 8;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH    = 2'd0,
      OP_CONSUME = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_NO_SPACE    = 2'd1,
      ST_DROPPED     = 2'd2,
      ST_BEYOND_FILL = 2'd3
   } status_type;

   // one request word as seen by the ring core
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] data_byte;
      logic [CNT_W-1:0]  message_length;
      logic              first_of_message;
      logic [CNT_W-1:0]  consume_count;
      logic [ADDR_W-1:0] read_offset;
   } req_item_type;

   // per-word outcome of the ring core
   typedef struct packed {
      status_type status;
      logic       read_hit;
   } core_rsp_type;

   // peek view of the committed ring
   typedef struct packed {
      logic [CNT_W-1:0]  fill_level;
      logic [ADDR_W-1:0] head_position;
      logic [CNT_W-1:0]  contiguous_available;
   } peek_type;

endpackage

// ----- hdl/brsq_ifs.sv -----
interface brsq_req_if
   import brsq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] data_byte;
   logic [CNT_W-1:0]  message_length;
   logic              first_of_message;
   logic [CNT_W-1:0]  consume_count;
   logic [ADDR_W-1:0] read_offset;

   modport source (
      output valid, operation, data_byte, message_length, first_of_message,
             consume_count, read_offset,
      input  ready
   );
   modport sink (
      input  valid, operation, data_byte, message_length, first_of_message,
             consume_count, read_offset,
      output ready
   );
endinterface

interface brsq_rsp_if
   import brsq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   read_data;
   logic [CNT_W-1:0]    fill_level;
   logic [ADDR_W-1:0]   head_position;
   logic [CNT_W-1:0]    contiguous_available;

   modport source (
      output valid, status, read_data, fill_level, head_position,
             contiguous_available,
      input  ready
   );
   modport sink (
      input  valid, status, read_data, fill_level, head_position,
             contiguous_available,
      output ready
   );
endinterface

// ----- hdl/brsq_ring_core.sv -----
module brsq_ring_core
   import brsq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  req_item_type       item,
   input  logic               csr_write_enable,
   input  logic [CNT_W-1:0]   csr_write_data,
   output core_rsp_type       info,
   output logic [BYTE_W-1:0]  rd_data,
   output peek_type           peek
);

   logic [BYTE_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0]  exp_ff, exp_in;
   logic              drop_ff, drop_in;
   logic [BYTE_W-1:0] rd_data_ff;

   logic              mem_we;
   logic              rd_en;
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;

   logic [CNT_W-1:0]  head_ext;
   logic [CNT_W-1:0]  base_sum, base_wrap;
   logic [CNT_W-1:0]  w1_sum, w1;
   logic [CNT_W-1:0]  e_base, e_new;
   logic [CNT_W-1:0]  span;
   logic [CNT_W-1:0]  free_space;
   logic [CNT_W-1:0]  n_eff, h_sum, h_wrap, fill_left;
   logic [CNT_W-1:0]  r_sum, r_wrap;
   logic [CNT_W-1:0]  to_end;
   logic              do_store;

   assign head_ext   = {1'b0, head_ff};
   assign free_space = cap_ff - fill_ff;

   // append position: end of committed data on a first word, else the open write index
   assign base_sum  = head_ext + fill_ff;
   assign base_wrap = (base_sum >= cap_ff) ? base_sum - cap_ff : base_sum;
   assign waddr     = item.first_of_message ? base_wrap[ADDR_W-1:0] : wr_ff;
   assign w1_sum    = {1'b0, waddr} + CNT_W'(1);
   assign w1        = (w1_sum == cap_ff) ? '0 : w1_sum;
   assign e_base    = item.first_of_message ? item.message_length : exp_ff;
   assign e_new     = e_base - CNT_W'(1);
   assign span      = ((w1 < head_ext) ? w1 + cap_ff : w1) - head_ext;

   // consume: clamp to fill, wrap the head
   assign n_eff     = (item.consume_count > fill_ff) ? fill_ff : item.consume_count;
   assign h_sum     = head_ext + n_eff;
   assign h_wrap    = (h_sum >= cap_ff) ? h_sum - cap_ff : h_sum;
   assign fill_left = fill_ff - n_eff;

   // read address relative to head
   assign r_sum  = head_ext + {1'b0, item.read_offset};
   assign r_wrap = (r_sum >= cap_ff) ? r_sum - cap_ff : r_sum;
   assign raddr  = r_wrap[ADDR_W-1:0];

   always_comb begin
      cap_in        = cap_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      wr_in         = wr_ff;
      exp_in        = exp_ff;
      drop_in       = drop_ff;
      rd_en         = 1'b0;
      do_store      = 1'b0;
      info.status   = ST_OK;
      info.read_hit = 1'b0;

      case (op_type'(item.operation))
         OP_PUSH: begin
            if (item.first_of_message) begin
               exp_in  = '0;
               drop_in = 1'b0;
               if (item.message_length == '0) begin
                  info.status = ST_DROPPED;
               end else if (item.message_length > free_space) begin
                  info.status = ST_NO_SPACE;
                  exp_in      = e_new;
                  drop_in     = (item.message_length != CNT_W'(1));
               end else begin
                  do_store = 1'b1;
               end
            end else if (drop_ff) begin
               info.status = ST_DROPPED;
               if (exp_ff != '0) exp_in = exp_ff - CNT_W'(1);
               if (exp_ff <= CNT_W'(1)) drop_in = 1'b0;
            end else if (exp_ff == '0) begin
               info.status = ST_DROPPED;
            end else begin
               do_store = 1'b1;
            end
            if (do_store) begin
               wr_in  = w1[ADDR_W-1:0];
               exp_in = e_new;
               // commit on the last word of the message
               if (e_new == '0) fill_in = (span == '0) ? cap_ff : span;
            end
         end
         OP_CONSUME: begin
            if (item.consume_count != '0) begin
               head_in = h_wrap[ADDR_W-1:0];
               fill_in = fill_left;
               if (fill_left == '0 && (exp_ff == '0 || drop_ff)) head_in = '0;
            end
         end
         OP_READ: begin
            if ({1'b0, item.read_offset} >= fill_ff) begin
               info.status = ST_BEYOND_FILL;
            end else begin
               info.read_hit = 1'b1;
               rd_en         = 1'b1;
            end
         end
         default: begin
            info.status = ST_DROPPED;
         end
      endcase

      if (!go) begin
         head_in  = head_ff;
         fill_in  = fill_ff;
         wr_in    = wr_ff;
         exp_in   = exp_ff;
         drop_in  = drop_ff;
         rd_en    = 1'b0;
         do_store = 1'b0;
      end

      // capacity write: clamp and empty the ring
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            cap_in = CNT_W'(1);
         end else if (csr_write_data > CNT_W'(DEPTH)) begin
            cap_in = CNT_W'(DEPTH);
         end else begin
            cap_in = csr_write_data;
         end
         head_in = '0;
         fill_in = '0;
         wr_in   = '0;
         exp_in  = '0;
         drop_in = 1'b0;
      end
   end

   assign mem_we = do_store;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CNT_W'(DEPTH);
         head_ff <= '0;
         fill_ff <= '0;
         wr_ff   <= '0;
         exp_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         cap_ff  <= cap_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
         wr_ff   <= wr_in;
         exp_ff  <= exp_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= item.data_byte;
      if (rd_en) rd_data_ff <= mem[raddr];
   end

   assign rd_data = rd_data_ff;

   assign to_end                    = cap_ff - head_ext;
   assign peek.fill_level           = fill_ff;
   assign peek.head_position        = head_ff;
   assign peek.contiguous_available = (fill_ff == '0)   ? '0 :
                                      (fill_ff < to_end) ? fill_ff : to_end;

endmodule

// ----- hdl/byte_ring_send_queue.sv -----
// A result word goes through the stage 1 register and then the output register. Throughput: one
// request word per cycle while responses drain; each word's pointer update finishes in the cycle
// it is taken, and the byte store gives one write and one registered read per cycle.
// Reset: synchronous, active high; clears the ring pointers and counts, capacity returns to
// 4096. Byte store contents stay undefined and need no clearing pass.
module byte_ring_send_queue
   import brsq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   brsq_req_if.sink           req_ch,
   brsq_rsp_if.source         rsp_ch,
   input  logic               csr_write_enable,
   input  logic [CNT_W-1:0]   csr_write_data
);

   req_item_type      item;
   core_rsp_type      info;
   logic [BYTE_W-1:0] rd_data;
   peek_type          peek;

   logic              accept;
   logic              s1_move;

   // stage 1: word taken, state updated, store read in flight
   logic              s1_valid_ff, s1_valid_in;
   core_rsp_type      s1_info_ff;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic [BYTE_W-1:0] out_read_data_ff;
   peek_type          out_peek_ff;

   // pack the request word for the core
   assign item.operation        = req_ch.operation;
   assign item.data_byte        = req_ch.data_byte;
   assign item.message_length   = req_ch.message_length;
   assign item.first_of_message = req_ch.first_of_message;
   assign item.consume_count    = req_ch.consume_count;
   assign item.read_offset      = req_ch.read_offset;

   // advance stage 1 whenever the output register is empty or being drained
   assign s1_move      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign accept       = req_ch.valid && req_ch.ready;

   brsq_ring_core u_core (
      .clock            (clock),
      .reset            (reset),
      .go               (accept),
      .item             (item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .info             (info),
      .rd_data          (rd_data),
      .peek             (peek)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) s1_valid_in = 1'b0;
      if (accept) s1_valid_in = 1'b1;

      out_valid_in = out_valid_ff;
      if (s1_move) out_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the outcome of the taken word until it moves to the output
   always_ff @(posedge clock) begin
      if (accept) s1_info_ff <= info;
   end

   // the core's pointers already reflect the stage 1 word, so the peek view is current
   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         out_status_ff    <= s1_info_ff.status;
         out_read_data_ff <= s1_info_ff.read_hit ? rd_data : '0;
         out_peek_ff      <= peek;
      end
   end

   assign rsp_ch.valid                = out_valid_ff;
   assign rsp_ch.status               = out_status_ff;
   assign rsp_ch.read_data            = out_read_data_ff;
   assign rsp_ch.fill_level           = out_peek_ff.fill_level;
   assign rsp_ch.head_position        = out_peek_ff.head_position;
   assign rsp_ch.contiguous_available = out_peek_ff.contiguous_available;

endmodule
